>>> rtl/pnss_pkg.sv
package pnss_pkg;

    typedef struct packed {
        logic signed [31:0] stress_xx;
        logic signed [31:0] stress_yy;
        logic signed [31:0] stress_zz;
        logic signed [31:0] stress_xy;
        logic signed [31:0] stress_yz;
        logic signed [31:0] stress_zx;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } pnss_in_t;

    typedef struct packed {
        logic signed [31:0] normal_stress;
        logic        [30:0] shear_stress;
    } pnss_out_t;

    localparam int SqW  = 64;
    localparam int RootW = 32;
    localparam int SqrtSteps = RootW;
    localparam int SqrtPerStage = 4;
    localparam int SqrtStages = SqrtSteps / SqrtPerStage;

endpackage

>>> rtl/plane_normal_shear_stress_unit.sv
// plane normal and shear stress unit
//
// request channel: drive the nine stress and normal fields on req with
// start high; a request is taken on every edge where start is high and busy
// is low. busy is tied low: the pipeline takes one request per cycle and
// never stalls.
// result channel: res carries normal_stress and shear_stress for exactly one
// cycle, marked by done. the receiver cannot hold results off and none is
// needed since the pipeline moves every cycle.
// throughput one per cycle. the pipeline holds the product stages (traction,
// normal, shear vector, squares) and the 32-step square root, four root bits
// per stage.
// reset clears all valid bits; payload registers are not reset and results
// in flight are dropped.
module plane_normal_shear_stress_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pnss_pkg::pnss_in_t   req,
    output logic                 done,
    output pnss_pkg::pnss_out_t  res
);
    import pnss_pkg::*;

    localparam int Lat = 8 + SqrtStages;

    logic [Lat-1:0] vld_reg;
    logic [Lat-1:0] vld_next;

    // stage 1: products of tensor and normal
    logic signed [47:0] p_reg [9];
    logic signed [15:0] n1_reg [3];
    // stage 2: traction
    logic signed [35:0] t_reg [3];
    logic signed [15:0] n2_reg [3];
    // stage 3: t * n products
    logic signed [51:0] q_reg [3];
    logic signed [35:0] t3_reg [3];
    logic signed [15:0] n3_reg [3];
    // stage 4: normal stress (unsaturated)
    logic signed [39:0] ns_reg;
    logic signed [35:0] t4_reg [3];
    logic signed [15:0] n4_reg [3];
    // stage 5: ns * n products
    logic signed [55:0] m_reg [3];
    logic signed [35:0] t5_reg [3];
    logic signed [31:0] nout5_reg;
    // stage 6: shear vector
    logic signed [42:0] v_reg [3];
    logic signed [31:0] nout6_reg;
    // stage 7: squares
    logic [61:0] sqp_reg [3];
    logic        big7_reg;
    logic signed [31:0] nout7_reg;
    // stage 8: sum of squares
    logic [SqW-1:0] sq_reg;
    logic           big8_reg;
    logic signed [31:0] nout8_reg;
    // sqrt stages
    logic [SqW-1:0]   rem_reg  [SqrtStages];
    logic [RootW-1:0] root_reg [SqrtStages];
    logic             bigs_reg [SqrtStages];
    logic signed [31:0] nouts_reg [SqrtStages];

    function automatic logic signed [63:0] rnd14(input logic signed [63:0] x);
        logic signed [63:0] y;
        begin
            y = x + 64'sd8192;
            return y >>> 14;
        end
    endfunction

    assign busy = 1'b0;

    always_comb
    begin
        vld_next = {vld_reg[Lat-2:0], start};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    logic signed [63:0] tsum [3];
    logic signed [63:0] nsum;
    logic signed [63:0] ns64;
    logic signed [63:0] vsum [3];
    logic [42:0] vabs [3];
    logic [SqW-1:0] rem_src  [SqrtStages];
    logic [RootW-1:0] root_src [SqrtStages];
    logic [SqW-1:0] rem_in  [SqrtStages];
    logic [RootW-1:0] root_in [SqrtStages];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tsum[i] = rnd14(64'(p_reg[3*i]) + 64'(p_reg[3*i+1]) + 64'(p_reg[3*i+2]));
            vsum[i] = rnd14((64'(t5_reg[i]) <<< 14) - 64'(m_reg[i]));
            vabs[i] = v_reg[i][42] ? 43'(-v_reg[i]) : 43'(v_reg[i]);
        end
        nsum = 64'(q_reg[0]) + 64'(q_reg[1]) + 64'(q_reg[2]);
        ns64 = rnd14(nsum);
    end

    // restoring square root, root bit k at pair position k
    always_comb
    begin
        rem_src[0]  = sq_reg;
        root_src[0] = '0;
        for (int s = 1; s < SqrtStages; s++)
        begin
            rem_src[s]  = rem_reg[s-1];
            root_src[s] = root_reg[s-1];
        end
        for (int s = 0; s < SqrtStages; s++)
        begin
            logic [SqW-1:0] r;
            logic [SqW-1:0] q;
            logic [SqW-1:0] trial;
            int k;
            r = rem_src[s];
            q = SqW'(root_src[s]);
            for (int j = 0; j < SqrtPerStage; j++)
            begin
                k = RootW - 1 - (s * SqrtPerStage + j);
                trial = (q << (k + 1)) | (SqW'(1) << (2 * k));
                if (r >= trial)
                begin
                    r = r - trial;
                    q = q | (SqW'(1) << k);
                end
            end
            rem_in[s]  = r;
            root_in[s] = RootW'(q);
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg[0] <= req.stress_xx * req.normal_x;
        p_reg[1] <= req.stress_xy * req.normal_y;
        p_reg[2] <= req.stress_zx * req.normal_z;
        p_reg[3] <= req.stress_xy * req.normal_x;
        p_reg[4] <= req.stress_yy * req.normal_y;
        p_reg[5] <= req.stress_yz * req.normal_z;
        p_reg[6] <= req.stress_zx * req.normal_x;
        p_reg[7] <= req.stress_yz * req.normal_y;
        p_reg[8] <= req.stress_zz * req.normal_z;
        n1_reg[0] <= req.normal_x;
        n1_reg[1] <= req.normal_y;
        n1_reg[2] <= req.normal_z;
        for (int i = 0; i < 3; i++)
        begin
            t_reg[i]  <= 36'(tsum[i]);
            n2_reg[i] <= n1_reg[i];
            q_reg[i]  <= t_reg[i] * n2_reg[i];
            t3_reg[i] <= t_reg[i];
            n3_reg[i] <= n2_reg[i];
            t4_reg[i] <= t3_reg[i];
            n4_reg[i] <= n3_reg[i];
            m_reg[i]  <= ns_reg * n4_reg[i];
            t5_reg[i] <= t4_reg[i];
            v_reg[i]  <= 43'(vsum[i]);
            sqp_reg[i] <= 62'(vabs[i][30:0]) * 62'(vabs[i][30:0]);
        end
        ns_reg <= 40'(ns64);
        nout5_reg <= (ns_reg > 40'sd2147483647) ? 32'sh7fffffff :
                     (ns_reg < -40'sd2147483648) ? 32'sh80000000 : 32'(ns_reg);
        nout6_reg <= nout5_reg;
        big7_reg <= (vabs[0] >= 43'h80000000) || (vabs[1] >= 43'h80000000)
                    || (vabs[2] >= 43'h80000000);
        nout7_reg <= nout6_reg;
        sq_reg <= SqW'(sqp_reg[0]) + SqW'(sqp_reg[1]) + SqW'(sqp_reg[2]);
        big8_reg <= big7_reg;
        nout8_reg <= nout7_reg;
        bigs_reg[0]  <= big8_reg;
        nouts_reg[0] <= nout8_reg;
        for (int s = 1; s < SqrtStages; s++)
        begin
            bigs_reg[s]  <= bigs_reg[s-1];
            nouts_reg[s] <= nouts_reg[s-1];
        end
        for (int s = 0; s < SqrtStages; s++)
        begin
            rem_reg[s]  <= rem_in[s];
            root_reg[s] <= root_in[s];
        end
    end

    logic [SqW-1:0]   fin_rem;
    logic [RootW-1:0] fin_root;
    logic [RootW:0]   rounded;

    always_comb
    begin
        fin_rem  = rem_reg[SqrtStages-1];
        fin_root = root_reg[SqrtStages-1];
        rounded  = (fin_rem > SqW'(fin_root)) ? (RootW+1)'(fin_root) + 1'b1
                                              : (RootW+1)'(fin_root);
        res.normal_stress = nouts_reg[SqrtStages-1];
        if (bigs_reg[SqrtStages-1] || rounded > (RootW+1)'(32'h7fffffff))
        begin
            res.shear_stress = 31'h7fffffff;
        end
        else
        begin
            res.shear_stress = rounded[30:0];
        end
        done = vld_reg[Lat-1];
    end

    a_busy_low: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy asserted");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(Lat) done)
        else $error("result missing after request");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, Lat))
        else $error("result without request");

endmodule

>>> tb/sv/tb_plane_normal_shear_stress_unit.sv
module tb_plane_normal_shear_stress_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pnss_pkg::*;

    localparam int Latency = 16;
    localparam int WatchdogLimit = 2000;
    localparam int RandomCount = 400;
    localparam int DirectedCount = 14;
    localparam int InW = $bits(pnss_in_t);

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    pnss_in_t req;
    logic done;
    pnss_out_t res;

    plane_normal_shear_stress_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .done(done),
        .res(res)
    );

    typedef struct {
        pnss_in_t  stim;
        logic      has_fixed;
        pnss_out_t fixed;
    } row_t;

    pnss_out_t stress_queue[$];
    int error_count;
    int request_count;
    int result_count;
    int idle_cycles;
    int saturated_shear;
    row_t rows[DirectedCount];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [63:0] round_q14(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = x + 64'sd8192;
        return y >>> 14;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic pnss_out_t predict_stress(input pnss_in_t r);
        logic signed [63:0] sxx, syy, szz, sxy, syz, szx;
        logic signed [63:0] n[3];
        logic signed [63:0] t[3];
        logic signed [63:0] v[3];
        logic signed [63:0] ns;
        logic [63:0] sq;
        logic [63:0] a;
        logic [63:0] root;
        logic big;
        pnss_out_t o;
        sxx = r.stress_xx; syy = r.stress_yy; szz = r.stress_zz;
        sxy = r.stress_xy; syz = r.stress_yz; szx = r.stress_zx;
        n[0] = r.normal_x; n[1] = r.normal_y; n[2] = r.normal_z;
        t[0] = round_q14(sxx * n[0] + sxy * n[1] + szx * n[2]);
        t[1] = round_q14(sxy * n[0] + syy * n[1] + syz * n[2]);
        t[2] = round_q14(szx * n[0] + syz * n[1] + szz * n[2]);
        ns = round_q14(t[0] * n[0] + t[1] * n[1] + t[2] * n[2]);
        if (ns > 64'sd2147483647)
            o.normal_stress = 32'h7fffffff;
        else if (ns < -64'sd2147483648)
            o.normal_stress = 32'h80000000;
        else
            o.normal_stress = ns[31:0];
        big = 1'b0;
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            v[i] = round_q14((t[i] <<< 14) - ns * n[i]);
            if (v[i] >= 64'sd2147483648 || v[i] <= -64'sd2147483648)
                big = 1'b1;
            a = v[i] < 0 ? -v[i] : v[i];
            sq = sq + a * a;
        end
        if (big)
            o.shear_stress = 31'h7fffffff;
        else
        begin
            root = int_sqrt(sq);
            if (sq - root * root > root)
                root = root + 1;
            o.shear_stress = root > 64'h7fffffff ? 31'h7fffffff : root[30:0];
        end
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic pnss_in_t random_request(input int mode);
        pnss_in_t r;
        r = InW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom});
        if (mode < 6)
        begin
            // moderate stresses, normals inside the unit range
            r.stress_xx = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
            r.stress_yy = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
            r.stress_zz = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
            r.stress_xy = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
            r.stress_yz = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
            r.stress_zx = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
            r.normal_x = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
            r.normal_y = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
            r.normal_z = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        end
        else if (mode < 8)
        begin
            r.normal_x = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
            r.normal_y = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
            r.normal_z = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        end
        return r;
    endfunction

    function automatic pnss_in_t make_request(input logic signed [31:0] s,
                                              input logic signed [31:0] sh,
                                              input logic signed [15:0] nx,
                                              input logic signed [15:0] ny,
                                              input logic signed [15:0] nz);
        pnss_in_t r;
        r.stress_xx = s; r.stress_yy = s; r.stress_zz = s;
        r.stress_xy = sh; r.stress_yz = sh; r.stress_zx = sh;
        r.normal_x = nx; r.normal_y = ny; r.normal_z = nz;
        return r;
    endfunction

    task automatic send_request(input pnss_in_t r, input logic has_fixed,
                                input pnss_out_t fixed);
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        request_count++;
        if (has_fixed)
            stress_queue.push_back(fixed);
        else
            stress_queue.push_back(predict_stress(r));
    endtask

    always @(posedge clk)
    begin
        pnss_out_t want;
        if (rst_n && done)
        begin
            result_count++;
            if (stress_queue.size() == 0)
            begin
                $display("result with no request outstanding at %0t", $time);
                error_count++;
            end
            else
            begin
                want = stress_queue.pop_front();
                if (res.normal_stress !== want.normal_stress)
                    report_mismatch("normal_stress", res.normal_stress, want.normal_stress);
                if (res.shear_stress !== want.shear_stress)
                    report_mismatch("shear_stress", {1'b0, res.shear_stress},
                                    {1'b0, want.shear_stress});
                if (want.shear_stress == 31'h7fffffff)
                    saturated_shear++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("FAIL plane_normal_shear_stress_unit");
            $finish;
        end
    end

    initial
    begin
        pnss_out_t none;
        none = '0;
        error_count = 0;
        request_count = 0;
        result_count = 0;
        idle_cycles = 0;
        saturated_shear = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        rows[0] = '{make_request(0, 0, 16384, 0, 0), 1'b1, '{32'sd0, 31'd0}};
        rows[1] = '{make_request(32'sh00010000, 0, 16384, 0, 0), 1'b1,
                    '{32'sh00010000, 31'd0}};
        rows[2] = '{make_request(32'sh00010000, 0, 0, -16384, 0), 1'b1,
                    '{32'sh00010000, 31'd0}};
        rows[3] = '{make_request(32'sh7fffffff, 32'sh7fffffff, 16384, 16384, 16384),
                    1'b1, '{32'sh7fffffff, 31'h7fffffff}};
        rows[4] = '{make_request(32'sh80000000, 32'sh80000000, 16384, 16384, 16384),
                    1'b1, '{32'sh80000000, 31'h7fffffff}};
        rows[5] = '{make_request(32'sh7fffffff, 0, 0, 0, 0), 1'b1, '{32'sd0, 31'd0}};
        rows[6] = '{make_request(0, 32'sh00010000, 16384, 0, 0), 1'b0, none};
        rows[7] = '{make_request(32'sh80000000, 32'sh7fffffff, -16384, 16384, -16384),
                    1'b0, none};
        rows[8] = '{make_request(32'sh12345678, 32'shedcba987, 16'sh7fff, 16'sh8000,
                    16'sh7fff), 1'b0, none};
        rows[9] = '{make_request(32'shffffffff, 32'sh00000001, 16'shffff, 16'sh8000,
                    16'sh0001), 1'b0, none};
        rows[10] = '{make_request(32'sh00400000, 32'shffc00000, 11585, 11585, 0),
                     1'b0, none};
        rows[11] = '{make_request(32'sh80000000, 0, -16384, 0, 0), 1'b1,
                     '{32'sh80000000, 31'd0}};
        rows[12] = '{make_request(32'sh5555aaaa, 32'shaaaa5555, 9459, 9459, 9459),
                     1'b0, none};
        rows[13] = '{make_request(32'sh7fffffff, 32'sh80000000, 16384, -16384, 0),
                     1'b0, none};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DirectedCount; i++)
        begin
            if ($urandom_range(0, 99) < 19)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            send_request(rows[i].stim, rows[i].has_fixed, rows[i].fixed);
        end
        for (int i = 0; i < RandomCount; i++)
        begin
            // a stretch in the middle runs back to back
            if ((i < 150 || i >= 250) && $urandom_range(0, 99) < 23)
            begin
                start <= 1'b0;
                req <= random_request($urandom_range(0, 9));
                @(posedge clk);
            end
            send_request(random_request($urandom_range(0, 9)), 1'b0, none);
        end
        start <= 1'b0;
        while (stress_queue.size() != 0)
            @(posedge clk);
        repeat (Latency + 4) @(posedge clk);
        $display("covered %0d requests, %0d results checked, %0d with saturated shear",
                 request_count, result_count, saturated_shear);
        if (error_count == 0)
            $display("PASS plane_normal_shear_stress_unit");
        else
            $display("FAIL plane_normal_shear_stress_unit");
        $finish;
    end

endmodule

>>> files.f
rtl/pnss_pkg.sv
rtl/plane_normal_shear_stress_unit.sv
tb/sv/tb_plane_normal_shear_stress_unit.sv
